// File: rtl/audio_ring_buffer_device_core_macros.svh
// assertion macros for the audio ring buffer core
// used by the top level only, no other dependencies
`ifndef AUDIO_RING_BUFFER_DEVICE_CORE_MACROS_SVH
`define AUDIO_RING_BUFFER_DEVICE_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ARBD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ARBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/arbd_pkg.sv
// shared types and constants for the audio ring buffer core
// no dependencies
`default_nettype none

package arbd_pkg;

   // sample buffer size in bytes, power of two
   localparam int ARBD_BUF_BYTES = 65536;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [2:0] {
      KIND_REG_WR  = 3'd0,
      KIND_REG_RD  = 3'd1,
      KIND_BUF_WR  = 3'd2,
      KIND_BUF_RD  = 3'd3,
      KIND_PULL    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      RIDX_FREQ     = 3'd0,
      RIDX_CHANNELS = 3'd1,
      RIDX_SAMPLES  = 3'd2,
      RIDX_SIZE     = 3'd3,
      RIDX_INIT     = 3'd4,
      RIDX_COUNT    = 3'd5
   } reg_idx_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_MEM  = 1'b1
   } state_type;

   typedef struct packed {
      logic accept;
      logic load_mem;
   } cmd_type;

   typedef struct packed {
      logic needs_mem;
   } sts_type;

endpackage

`default_nettype wire

// File: rtl/audio_ring_buffer_device_core.sv
// channel  dir  tdata (low bit up)                                   tuser
// req      in   reg_index[2:0] write_word[34:3] buf_addr[50:35]       kind[2:0]
//               buf_byte[58:51], zero above
// rsp      out  read_word[31:0] out_byte[39:32]                      play_valid[0]
//
// register accesses, buffer writes, empty pulls and out-of-range buffer reads are
// answered directly; in-range buffer reads and data-carrying pulls go through a
// memory wait state: the sample store has one registered read port
// a word held in the output register stalls req; req is taken as it leaves
// reset clears the register bank and pointers; the sample store and the result register are not cleared
// BUF_BYTES must be a power of two
`default_nettype none

`include "audio_ring_buffer_device_core_macros.svh"

module audio_ring_buffer_device_core
   import arbd_pkg::*;
#(
   parameter int BUF_BYTES = ARBD_BUF_BYTES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // reg_index, write_word, buf_addr, buf_byte
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // kind
   input  wire logic [2:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // read_word, out_byte
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // play_valid
   output logic [0:0]                 rsp_tuser
);

   cmd_type     cmd;
   sts_type     sts;
   logic [31:0] read_word;
   logic [7:0]  out_byte;
   logic        play_valid;

   arbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   arbd_dp #(
      .BUF_BYTES (BUF_BYTES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .kind          (req_tuser),
      .reg_index     (req_tdata[2:0]),
      .write_word    (req_tdata[34:3]),
      .buf_addr      (req_tdata[50:35]),
      .buf_byte      (req_tdata[58:51]),
      .cmd           (cmd),
      .sts           (sts),
      .read_word_ff  (read_word),
      .out_byte_ff   (out_byte),
      .play_valid_ff (play_valid)
   );

   assign rsp_tdata    = {out_byte, read_word};
   assign rsp_tuser[0] = play_valid;

   `ARBD_ASSERT_SAME(a_no_accept_in_wait, clock, reset, cmd.load_mem, !req_tready, "item taken during memory wait")
   `ARBD_ASSERT_NEXT(a_mem_follows, clock, reset, cmd.accept && sts.needs_mem, cmd.load_mem, "memory read not completed")
   `ARBD_ASSERT_NEXT(a_direct_word, clock, reset, cmd.accept && !sts.needs_mem, rsp_tvalid, "direct result missing")
   `ARBD_ASSERT_NEXT(a_mem_word, clock, reset, cmd.load_mem, rsp_tvalid, "memory result missing")

endmodule

`default_nettype wire

// File: rtl/arbd_ram.sv
// generic single write port, single registered read port ram
// no dependencies
`default_nettype none

module arbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/arbd_ctrl.sv
// controller: handshake and the wait state for buffer memory reads
// depends on arbd_pkg
`default_nettype none

module arbd_ctrl
   import arbd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   input  wire logic    rsp_tready,
   input  wire sts_type sts,
   output logic         req_tready,
   output logic         rsp_tvalid,
   output cmd_type      cmd
);

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      req_tready   = 1'b0;
      cmd.accept   = 1'b0;
      cmd.load_mem = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // output register is free or drains this cycle
            req_tready = !out_valid_ff || rsp_tready;
            cmd.accept = req_tvalid && req_tready;
            if (cmd.accept) begin
               if (sts.needs_mem) begin
                  state_in     = ST_MEM;
                  out_valid_in = 1'b0;
               end else begin
                  out_valid_in = 1'b1;
               end
            end else if (rsp_tready) begin
               out_valid_in = 1'b0;
            end
         end
         ST_MEM: begin
            cmd.load_mem = 1'b1;
            out_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in     = ST_IDLE;
            out_valid_in = 1'b0;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

`default_nettype wire

// File: rtl/arbd_dp.sv
// datapath: register bank, ring pointers, sample store and result register
// depends on arbd_pkg and arbd_ram
`default_nettype none

module arbd_dp
   import arbd_pkg::*;
#(
   parameter int BUF_BYTES = ARBD_BUF_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [2:0]  kind,
   input  wire logic [2:0]  reg_index,
   input  wire logic [31:0] write_word,
   input  wire logic [15:0] buf_addr,
   input  wire logic [7:0]  buf_byte,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output logic [31:0]      read_word_ff,
   output logic [7:0]       out_byte_ff,
   output logic             play_valid_ff
);

   localparam int          PTR_W     = $clog2(BUF_BYTES);
   localparam logic [31:0] SIZE_WORD = 32'(BUF_BYTES);

   logic [31:0]      freq_ff, channels_ff, samples_ff, init_ff;
   logic             started_ff;
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;

   logic [PTR_W-1:0] fill;
   logic             empty;
   logic             addr_ok;
   logic [PTR_W-1:0] addr_idx;
   logic             ram_wr_en;
   logic [PTR_W-1:0] ram_rd_addr;
   logic [7:0]       ram_rd_data;
   logic [31:0]      reg_rd_word;
   logic [31:0]      read_word_in;
   logic             play_valid_in;

   // wraps for free since the size is a power of two
   assign fill     = wr_ptr_ff - rd_ptr_ff;
   assign empty    = (fill == '0);
   assign addr_ok  = (32'(buf_addr) < SIZE_WORD);
   assign addr_idx = PTR_W'(buf_addr);

   assign sts.needs_mem = ((kind == KIND_BUF_RD) && addr_ok) ||
                          ((kind == KIND_PULL) && !empty);

   assign ram_wr_en   = cmd.accept && (kind == KIND_BUF_WR) && addr_ok;
   assign ram_rd_addr = (kind == KIND_PULL) ? rd_ptr_ff : addr_idx;

   arbd_ram #(
      .WIDTH (8),
      .DEPTH (BUF_BYTES)
   ) u_store (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (addr_idx),
      .wr_data    (buf_byte),
      .rd_en      (cmd.accept && sts.needs_mem),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   always_comb begin
      case (reg_index)
         RIDX_FREQ:     reg_rd_word = freq_ff;
         RIDX_CHANNELS: reg_rd_word = channels_ff;
         RIDX_SAMPLES:  reg_rd_word = samples_ff;
         RIDX_SIZE:     reg_rd_word = SIZE_WORD;
         RIDX_INIT:     reg_rd_word = init_ff;
         RIDX_COUNT:    reg_rd_word = 32'(fill);
         default:       reg_rd_word = '0;
      endcase
   end

   always_comb begin
      read_word_in  = '0;
      play_valid_in = 1'b0;
      case (kind)
         KIND_REG_RD: read_word_in  = reg_rd_word;
         KIND_PULL:   play_valid_in = !empty;
         default:     read_word_in  = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff     <= '0;
         channels_ff <= '0;
         samples_ff  <= '0;
         init_ff     <= '0;
         started_ff  <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
      end else if (cmd.accept) begin
         if (kind == KIND_REG_WR) begin
            case (reg_index)
               RIDX_FREQ:     freq_ff     <= write_word;
               RIDX_CHANNELS: channels_ff <= write_word;
               RIDX_SAMPLES:  samples_ff  <= write_word;
               RIDX_INIT: begin
                  init_ff <= write_word;
                  // first init write only starts the device
                  if (!started_ff) begin
                     started_ff <= 1'b1;
                  end else begin
                     wr_ptr_ff <= wr_ptr_ff + write_word[PTR_W-1:0];
                  end
               end
               default: ;
            endcase
         end
         if ((kind == KIND_PULL) && !empty) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // result register; on memory reads the byte lands in the cycle after the word
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         read_word_ff  <= read_word_in;
         play_valid_ff <= play_valid_in;
         out_byte_ff   <= '0;
      end else if (cmd.load_mem) begin
         out_byte_ff <= ram_rd_data;
      end
   end

endmodule

`default_nettype wire
